// ----- hw/rtl/tqtd_pkg.sv -----
package tqtd_pkg;

  localparam int SLOW_DEPTH   = 16;
  localparam int MEDIUM_DEPTH = 16;
  localparam int FAST_DEPTH   = 16;
  localparam int TASK_W       = 16;

  localparam int SLOW_IW   = (SLOW_DEPTH > 1) ? $clog2(SLOW_DEPTH) : 1;
  localparam int MEDIUM_IW = (MEDIUM_DEPTH > 1) ? $clog2(MEDIUM_DEPTH) : 1;
  localparam int FAST_IW   = (FAST_DEPTH > 1) ? $clog2(FAST_DEPTH) : 1;

  localparam logic [SLOW_IW-1:0]   SLOW_LAST   = SLOW_IW'(SLOW_DEPTH - 1);
  localparam logic [MEDIUM_IW-1:0] MEDIUM_LAST = MEDIUM_IW'(MEDIUM_DEPTH - 1);
  localparam logic [FAST_IW-1:0]   FAST_LAST   = FAST_IW'(FAST_DEPTH - 1);

  localparam int PHASE_W = 3;

  typedef enum logic [2:0] {
    KIND_PUSH_SLOW   = 3'd0,
    KIND_PUSH_MEDIUM = 3'd1,
    KIND_PUSH_FAST   = 3'd2,
    KIND_PUSH_PAIR   = 3'd3,
    KIND_TICK_SLOW   = 3'd4,
    KIND_TICK_MEDIUM = 3'd5,
    KIND_TICK_FAST   = 3'd6
  } kind_t;

endpackage

// ----- hw/rtl/three_queue_tick_task_dispatcher.sv -----
// The result item of an accepted item is registered on the next cycle.
// Throughput: one item per cycle unless a full output is not drained; all
// queue work is done in the cycle of acceptance and the result waits in a single output register.
// in_ready is high whenever the output register is empty or being drained.
// Reset clears heads, tails, tick phases and the output valid; the task
// slots are not cleared and hold unknown data until written.
module three_queue_tick_task_dispatcher (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [15:0] task_first,
  input  logic [15:0] task_second,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        status,
  output logic        task_valid,
  output logic [15:0] task_out
);

  logic [tqtd_pkg::TASK_W-1:0] slow_store   [tqtd_pkg::SLOW_DEPTH];
  logic [tqtd_pkg::TASK_W-1:0] medium_store [tqtd_pkg::MEDIUM_DEPTH];
  logic [tqtd_pkg::TASK_W-1:0] fast_store   [tqtd_pkg::FAST_DEPTH];

  logic [tqtd_pkg::SLOW_IW-1:0]   slow_head, slow_tail, slow_head_inc, slow_tail_inc;
  logic [tqtd_pkg::MEDIUM_IW-1:0] medium_head, medium_tail, medium_head_inc, medium_tail_inc;
  logic [tqtd_pkg::FAST_IW-1:0]   fast_head, fast_tail, fast_head_inc, fast_tail_inc;
  logic [tqtd_pkg::FAST_IW-1:0]   fast_tail_inc2;
  logic [tqtd_pkg::SLOW_IW-1:0]   slow_head_next, slow_tail_next;
  logic [tqtd_pkg::MEDIUM_IW-1:0] medium_head_next, medium_tail_next;
  logic [tqtd_pkg::FAST_IW-1:0]   fast_head_next, fast_tail_next;

  logic [tqtd_pkg::PHASE_W-1:0] slow_phase, medium_phase, fast_phase;
  logic [tqtd_pkg::PHASE_W-1:0] slow_phase_next, medium_phase_next, fast_phase_next;

  logic slow_full, medium_full, fast_full, fast_pair_full;
  logic slow_we, medium_we, fast_we, fast_we2;
  logic slow_deq, medium_deq, fast_deq;
  logic acc;
  logic status_next, task_valid_next;

  assign in_ready = !out_valid || out_ready;
  assign acc      = in_valid && in_ready;

  assign slow_head_inc   = (slow_head == tqtd_pkg::SLOW_LAST) ? '0 : slow_head + 1'b1;
  assign slow_tail_inc   = (slow_tail == tqtd_pkg::SLOW_LAST) ? '0 : slow_tail + 1'b1;
  assign medium_head_inc = (medium_head == tqtd_pkg::MEDIUM_LAST) ? '0 : medium_head + 1'b1;
  assign medium_tail_inc = (medium_tail == tqtd_pkg::MEDIUM_LAST) ? '0 : medium_tail + 1'b1;
  assign fast_head_inc   = (fast_head == tqtd_pkg::FAST_LAST) ? '0 : fast_head + 1'b1;
  assign fast_tail_inc   = (fast_tail == tqtd_pkg::FAST_LAST) ? '0 : fast_tail + 1'b1;
  assign fast_tail_inc2  = (fast_tail_inc == tqtd_pkg::FAST_LAST) ? '0 : fast_tail_inc + 1'b1;

  assign slow_full      = (slow_tail_inc == slow_head);
  assign medium_full    = (medium_tail_inc == medium_head);
  assign fast_full      = (fast_tail_inc == fast_head);
  assign fast_pair_full = fast_full || (fast_tail_inc2 == fast_head);

  always_comb begin
    slow_head_next    = slow_head;
    slow_tail_next    = slow_tail;
    medium_head_next  = medium_head;
    medium_tail_next  = medium_tail;
    fast_head_next    = fast_head;
    fast_tail_next    = fast_tail;
    slow_phase_next   = slow_phase;
    medium_phase_next = medium_phase;
    fast_phase_next   = fast_phase;
    slow_we           = 1'b0;
    medium_we         = 1'b0;
    fast_we           = 1'b0;
    fast_we2          = 1'b0;
    slow_deq          = 1'b0;
    medium_deq        = 1'b0;
    fast_deq          = 1'b0;
    status_next       = 1'b0;
    task_valid_next   = 1'b0;
    case (kind)
      tqtd_pkg::KIND_PUSH_SLOW: begin
        status_next = slow_full;
        if (!slow_full) begin
          slow_we        = 1'b1;
          slow_tail_next = slow_tail_inc;
        end
      end
      tqtd_pkg::KIND_PUSH_MEDIUM: begin
        status_next = medium_full;
        if (!medium_full) begin
          medium_we        = 1'b1;
          medium_tail_next = medium_tail_inc;
        end
      end
      tqtd_pkg::KIND_PUSH_FAST: begin
        status_next = fast_full;
        if (!fast_full) begin
          fast_we        = 1'b1;
          fast_tail_next = fast_tail_inc;
        end
      end
      tqtd_pkg::KIND_PUSH_PAIR: begin
        status_next = fast_pair_full;
        if (!fast_pair_full) begin
          fast_we        = 1'b1;
          fast_we2       = 1'b1;
          fast_tail_next = fast_tail_inc2;
        end
      end
      tqtd_pkg::KIND_TICK_SLOW: begin
        slow_phase_next = slow_phase + 1'b1;
        if (slow_phase != '0 && slow_head != slow_tail) begin
          task_valid_next = 1'b1;
          slow_deq        = 1'b1;
          slow_head_next  = slow_head_inc;
        end
      end
      tqtd_pkg::KIND_TICK_MEDIUM: begin
        medium_phase_next = medium_phase + 1'b1;
        if (medium_phase != '0 && medium_head != medium_tail) begin
          task_valid_next  = 1'b1;
          medium_deq       = 1'b1;
          medium_head_next = medium_head_inc;
        end
      end
      tqtd_pkg::KIND_TICK_FAST: begin
        fast_phase_next = fast_phase + 1'b1;
        if (fast_phase == '0 && fast_head != fast_tail) begin
          task_valid_next = 1'b1;
          fast_deq        = 1'b1;
          fast_head_next  = fast_head_inc;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (acc && slow_we) begin
      slow_store[slow_tail] <= tqtd_pkg::TASK_W'(task_first);
    end
    if (acc && medium_we) begin
      medium_store[medium_tail] <= tqtd_pkg::TASK_W'(task_first);
    end
    if (acc && fast_we) begin
      fast_store[fast_tail] <= tqtd_pkg::TASK_W'(task_first);
    end
    if (acc && fast_we2) begin
      fast_store[fast_tail_inc] <= tqtd_pkg::TASK_W'(task_second);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slow_head    <= '0;
      slow_tail    <= '0;
      medium_head  <= '0;
      medium_tail  <= '0;
      fast_head    <= '0;
      fast_tail    <= '0;
      slow_phase   <= '0;
      medium_phase <= '0;
      fast_phase   <= '0;
      out_valid    <= 1'b0;
    end else if (acc) begin
      slow_head    <= slow_head_next;
      slow_tail    <= slow_tail_next;
      medium_head  <= medium_head_next;
      medium_tail  <= medium_tail_next;
      fast_head    <= fast_head_next;
      fast_tail    <= fast_tail_next;
      slow_phase   <= slow_phase_next;
      medium_phase <= medium_phase_next;
      fast_phase   <= fast_phase_next;
      out_valid    <= 1'b1;
      status       <= status_next;
      task_valid   <= task_valid_next;
      if (slow_deq) begin
        task_out <= 16'(slow_store[slow_head]);
      end else if (medium_deq) begin
        task_out <= 16'(medium_store[medium_head]);
      end else if (fast_deq) begin
        task_out <= 16'(fast_store[fast_head]);
      end else begin
        task_out <= '0;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_result_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid && task_valid |-> !status)
    else $error("dequeued task reported with refused status");

  a_idle_task_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !task_valid |-> task_out == '0)
    else $error("task_out nonzero without a dequeued task");

  a_refused_pair_holds: assert property (@(posedge clk) disable iff (rst)
    acc && kind == tqtd_pkg::KIND_PUSH_PAIR && fast_pair_full
      |=> fast_tail == $past(fast_tail) && status)
    else $error("refused pair push moved the fast tail");

  a_empty_tick: assert property (@(posedge clk) disable iff (rst)
    acc && kind == tqtd_pkg::KIND_TICK_SLOW && slow_head == slow_tail
      |=> !task_valid && slow_head == $past(slow_head))
    else $error("tick on empty slow queue dequeued a task");

  a_fast_phase: assert property (@(posedge clk) disable iff (rst)
    acc && kind == tqtd_pkg::KIND_TICK_FAST && fast_phase != '0 |=> !task_valid)
    else $error("fast queue dequeued off phase zero");

endmodule
